[src/dsf_pkg.sv]
// Shared widths, types and helpers for the damped spring force pipeline.
`default_nettype none
package dsf_pkg;
	localparam int FRAC_BITS = 16;
	localparam int IN_W = 32;
	localparam int CFG_W = 31;
	localparam int D_W = IN_W + 1;
	localparam int SQ_W = 2 * D_W;
	localparam int LEN_W = D_W;
	localparam int N_W = FRAC_BITS + 2;
	localparam int REM_W = LEN_W + FRAC_BITS;

	typedef enum logic [1:0] {
		REG_REST = 2'd0,
		REG_SPRING = 2'd1,
		REG_DAMP = 2'd2
	} reg_idx_t;

	typedef logic signed [IN_W-1:0] word_t;
	typedef logic signed [D_W-1:0] dval_t;
	typedef logic signed [N_W-1:0] nval_t;

	typedef struct packed {
		logic deg;
		dval_t [2:0] d;
		dval_t [2:0] r;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] rest;
		logic [CFG_W-1:0] k;
		logic [CFG_W-1:0] b;
	} cfg_t;

	typedef struct packed {
		logic deg;
		word_t [2:0] f;
	} res_t;

	function automatic logic [D_W-1:0] mag(input dval_t v);
		logic [D_W-1:0] u;
		u = v;
		return v[D_W-1] ? (~u + D_W'(1)) : u;
	endfunction
endpackage
`default_nettype wire

[src/dsf_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module dsf_sqrt (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic [dsf_pkg::SQ_W-1:0] rad,
	input dsf_pkg::item_t in_item,
	output logic out_v,
	output logic [dsf_pkg::LEN_W-1:0] root,
	output dsf_pkg::item_t out_item
);
	import dsf_pkg::*;

	logic vld_s [0:LEN_W];
	logic [SQ_W:0] rem_s [0:LEN_W];
	logic [LEN_W-1:0] root_s [0:LEN_W];
	item_t item_s [0:LEN_W];

	assign vld_s[0] = in_v;
	assign rem_s[0] = (SQ_W+1)'(rad);
	assign root_s[0] = '0;
	assign item_s[0] = in_item;

	for (genvar k = 0; k < LEN_W; k++) begin : g_stage
		localparam int B = LEN_W - 1 - k;
		logic [SQ_W:0] trial;
		assign trial = ((SQ_W+1)'(root_s[k]) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					root_s[k+1] <= root_s[k] | (LEN_W'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
				item_s[k+1] <= item_s[k];
			end
		end
	end

	assign out_v = vld_s[LEN_W];
	assign root = root_s[LEN_W];
	assign out_item = item_s[LEN_W];
endmodule
`default_nettype wire

[src/dsf_div.sv]
// Pipelined restoring divider that forms the three unit direction components.
`default_nettype none
module dsf_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic [dsf_pkg::LEN_W-1:0] len,
	input dsf_pkg::item_t in_item,
	output logic out_v,
	output logic [dsf_pkg::LEN_W-1:0] out_len,
	output dsf_pkg::nval_t [2:0] n,
	output dsf_pkg::item_t out_item
);
	import dsf_pkg::*;

	localparam int NST = FRAC_BITS + 1;

	logic vld_s [0:NST];
	logic [LEN_W-1:0] len_s [0:NST];
	item_t item_s [0:NST];
	logic [REM_W-1:0] rem_s [0:NST][3];
	logic [N_W-2:0] quo_s [0:NST][3];

	assign vld_s[0] = in_v;
	assign len_s[0] = len;
	assign item_s[0] = in_item;

	for (genvar a = 0; a < 3; a++) begin : g_init
		assign rem_s[0][a] = REM_W'(mag(in_item.d[a])) << FRAC_BITS;
		assign quo_s[0][a] = '0;
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam int J = FRAC_BITS - k;
		logic [REM_W-1:0] trial;
		assign trial = REM_W'(len_s[k]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < 3; a++) begin
					if (rem_s[k][a] >= trial) begin
						rem_s[k+1][a] <= rem_s[k][a] - trial;
						quo_s[k+1][a] <= quo_s[k][a] | ((N_W-1)'(1) << J);
					end else begin
						rem_s[k+1][a] <= rem_s[k][a];
						quo_s[k+1][a] <= quo_s[k][a];
					end
				end
				len_s[k+1] <= len_s[k];
				item_s[k+1] <= item_s[k];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (item_s[NST].d[a][D_W-1]) begin
				n[a] = -$signed({1'b0, quo_s[NST][a]});
			end else begin
				n[a] = $signed({1'b0, quo_s[NST][a]});
			end
		end
	end

	assign out_v = vld_s[NST];
	assign out_len = len_s[NST];
	assign out_item = item_s[NST];
endmodule
`default_nettype wire

[src/dsf_force.sv]
// Damping projection, spring scalar and final force scaling with saturation.
`default_nettype none
module dsf_force (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic [dsf_pkg::LEN_W-1:0] len,
	input dsf_pkg::nval_t [2:0] n,
	input dsf_pkg::item_t in_item,
	input dsf_pkg::cfg_t cfg,
	output logic out_v,
	output dsf_pkg::res_t res
);
	import dsf_pkg::*;

	localparam int PR_W = D_W + N_W;
	localparam int VS_W = PR_W + 2;
	localparam int VD_W = VS_W - FRAC_BITS;
	localparam int ST_W = LEN_W + 2;
	localparam int KM_W = CFG_W + 1 + ST_W;
	localparam int BM_W = CFG_W + 1 + VD_W;
	localparam int T_W = ((KM_W > BM_W) ? KM_W : BM_W) + 1;
	localparam int S_W = T_W - FRAC_BITS;
	localparam int FM_W = S_W + N_W;
	localparam int Q_W = FM_W - FRAC_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic deg_s1, deg_s2, deg_s3, deg_s4, deg_s5, deg_s6;
	nval_t [2:0] n_s1, n_s2, n_s3, n_s4;
	logic signed [PR_W-1:0] pr_s1 [3];
	logic signed [ST_W-1:0] stretch_s1;
	logic signed [VD_W-1:0] vdot_s2;
	logic signed [KM_W-1:0] km_s2, km_s3;
	logic signed [BM_W-1:0] bm_s3;
	logic signed [S_W-1:0] s_s4;
	logic signed [FM_W-1:0] fm_s5 [3];
	word_t [2:0] f_s6;

	logic signed [VS_W-1:0] vsum;
	logic signed [T_W-1:0] tsum;
	logic signed [Q_W-1:0] qv [3];
	word_t [2:0] sat;

	always_comb begin
		vsum = VS_W'(pr_s1[0]) + VS_W'(pr_s1[1]) + VS_W'(pr_s1[2]);
		tsum = T_W'(km_s3) - T_W'(bm_s3);
		for (int a = 0; a < 3; a++) begin
			qv[a] = fm_s5[a][FM_W-1:FRAC_BITS];
			if (qv[a] > Q_W'(32'sh7FFFFFFF)) begin
				sat[a] = 32'sh7FFFFFFF;
			end else if (qv[a] < -(Q_W'(33'sh080000000))) begin
				sat[a] = 32'sh80000000;
			end else begin
				sat[a] = qv[a][IN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				pr_s1[a] <= PR_W'(in_item.r[a]) * PR_W'(n[a]);
			end
			stretch_s1 <= $signed({2'b00, len}) - $signed(ST_W'(cfg.rest));
			n_s1 <= n;
			deg_s1 <= in_item.deg;

			vdot_s2 <= vsum[VS_W-1:FRAC_BITS];
			km_s2 <= KM_W'($signed({1'b0, cfg.k})) * KM_W'(stretch_s1);
			n_s2 <= n_s1;
			deg_s2 <= deg_s1;

			bm_s3 <= BM_W'($signed({1'b0, cfg.b})) * BM_W'(vdot_s2);
			km_s3 <= km_s2;
			n_s3 <= n_s2;
			deg_s3 <= deg_s2;

			s_s4 <= tsum[T_W-1:FRAC_BITS];
			n_s4 <= n_s3;
			deg_s4 <= deg_s3;

			for (int a = 0; a < 3; a++) begin
				fm_s5[a] <= FM_W'(s_s4) * FM_W'(n_s4[a]);
			end
			deg_s5 <= deg_s4;

			for (int a = 0; a < 3; a++) begin
				f_s6[a] <= deg_s5 ? '0 : sat[a];
			end
			deg_s6 <= deg_s5;
		end
	end

	assign out_v = v_s6;
	assign res.deg = deg_s6;
	assign res.f = f_s6;
endmodule
`default_nettype wire

[src/damped_spring_force_3d.sv]
// Top level of the damped spring force pipeline.
// One request enters per cycle while in_ready is high, and its force reaches the output
// after passing every stage listed next. Three input stages form the offset and its squared
// length, and the square root (one bit per stage over 33 stages), the divider (17 stages),
// six force stages and the output register make up the rest. An output
// register with a one-entry skid stage lets the pipeline advance one more result while
// the output waits; once the skid entry is full, in_ready drops until the output is taken.
// Register writes take effect at once and must only be made while no request is in flight.
`default_nettype none
module damped_spring_force_3d (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [dsf_pkg::CFG_W-1:0] wr_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [dsf_pkg::IN_W-1:0] pos_x,
	input logic signed [dsf_pkg::IN_W-1:0] pos_y,
	input logic signed [dsf_pkg::IN_W-1:0] pos_z,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_x,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_y,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_z,
	input logic signed [dsf_pkg::IN_W-1:0] vel_x,
	input logic signed [dsf_pkg::IN_W-1:0] vel_y,
	input logic signed [dsf_pkg::IN_W-1:0] vel_z,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_vel_x,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_vel_y,
	input logic signed [dsf_pkg::IN_W-1:0] anchor_vel_z,
	output logic out_valid,
	input logic out_ready,
	output logic signed [dsf_pkg::IN_W-1:0] force_x,
	output logic signed [dsf_pkg::IN_W-1:0] force_y,
	output logic signed [dsf_pkg::IN_W-1:0] force_z,
	output logic degenerate
);
	import dsf_pkg::*;

	cfg_t cfg_q;
	logic en;

	logic v_s1, v_s2, v_s3;
	item_t item_s1, item_s2, item_s3;
	logic [SQ_W-1:0] sq_s2 [3];
	logic [SQ_W-1:0] rad_s3;
	item_t item_in;

	logic sq_v;
	logic [LEN_W-1:0] sq_len;
	item_t sq_item;
	logic div_v;
	logic [LEN_W-1:0] div_len;
	nval_t [2:0] div_n;
	item_t div_item;
	logic p_v;
	res_t p_res;

	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest <= CFG_W'(1) << FRAC_BITS;
			cfg_q.k <= CFG_W'(1) << FRAC_BITS;
			cfg_q.b <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_REST: cfg_q.rest <= wr_data;
				REG_SPRING: cfg_q.k <= wr_data;
				REG_DAMP: cfg_q.b <= wr_data;
				default: ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_ready = en;

	always_comb begin
		item_in.d[0] = D_W'(anchor_x) - D_W'(pos_x);
		item_in.d[1] = D_W'(anchor_y) - D_W'(pos_y);
		item_in.d[2] = D_W'(anchor_z) - D_W'(pos_z);
		item_in.r[0] = D_W'(vel_x) - D_W'(anchor_vel_x);
		item_in.r[1] = D_W'(vel_y) - D_W'(anchor_vel_y);
		item_in.r[2] = D_W'(vel_z) - D_W'(anchor_vel_z);
		item_in.deg = (item_in.d[0] == '0) && (item_in.d[1] == '0) && (item_in.d[2] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= SQ_W'(mag(item_s1.d[a])) * SQ_W'(mag(item_s1.d[a]));
			end
			item_s2 <= item_s1;
			rad_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			item_s3 <= item_s2;
		end
	end

	dsf_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(v_s3),
		.rad(rad_s3),
		.in_item(item_s3),
		.out_v(sq_v),
		.root(sq_len),
		.out_item(sq_item)
	);

	dsf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(sq_v),
		.len(sq_len),
		.in_item(sq_item),
		.out_v(div_v),
		.out_len(div_len),
		.n(div_n),
		.out_item(div_item)
	);

	dsf_force u_force (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(div_v),
		.len(div_len),
		.n(div_n),
		.in_item(div_item),
		.cfg(cfg_q),
		.out_v(p_v),
		.res(p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= p_v;
			end
		end else if (p_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : p_res;
		end else if (!skid_v_q) begin
			skid_q <= p_res;
		end
	end

	assign out_valid = out_v_q;
	assign force_x = out_q.f[0];
	assign force_y = out_q.f[1];
	assign force_z = out_q.f[2];
	assign degenerate = out_q.deg;
endmodule
`default_nettype wire

[src/dsf_checker.sv]
// Port-level checks for the damped spring force block and their binding.
`default_nettype none
module dsf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic signed [31:0] force_z,
	input logic degenerate
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(force_x) && $stable(force_y)
			&& $stable(force_z) && $stable(degenerate))
		else $error("result request changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> force_x == 0 && force_y == 0 && force_z == 0)
		else $error("coincident points gave a nonzero force");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");
endmodule

bind damped_spring_force_3d dsf_checker u_dsf_checker (.*);
`default_nettype wire
